FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/iba_pkg.sv
// types and constants of the indexed block allocator
package iba_pkg;

    localparam int DISK_BLOCKS     = 128;
    localparam int BLK_W           = 7;
    localparam int FILE_SLOTS      = 32;
    localparam int SLOT_W          = 5;
    localparam int MAX_FILE_BLOCKS = 64;
    localparam int LIST_W          = 6;
    localparam int CNT_W           = 7;
    localparam int FREE_W          = 8;
    localparam int KEY_W           = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_EXISTS    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_BAD_COUNT = 3'd5;

    // what the result index carries
    localparam logic [1:0] IDX_ZERO  = 2'd0;
    localparam logic [1:0] IDX_START = 2'd1;
    localparam logic [1:0] IDX_LIST  = 2'd2;

    typedef struct packed {
        logic       in_ready;
        logic       load;
        logic       scan_step;
        logic       alloc_step;
        logic       mem_rd;
        logic       free_wr;
        logic       list_step;
        logic       emit;
        logic [2:0] emit_status;
        logic [1:0] emit_kind;
        logic       emit_last;
    } ctrl_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_cmd;
        logic [1:0] cmd_q;
        logic       count_bad;
        logic       no_space;
        logic       match;
        logic       vacant;
        logic       scan_last;
        logic       alloc_last;
        logic       blk_last;
        logic       out_free;
    } stat_t;

endpackage

FILE: src/iba_if.sv
// request and response channel interfaces
interface alloc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] file_key;
    logic [6:0]  block_count;

    modport source (output valid, cmd, file_key, block_count, input ready);
    modport sink (input valid, cmd, file_key, block_count, output ready);
endinterface

interface alloc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [6:0] block_index;
    logic [7:0] free_blocks;
    logic       last;

    modport source (output valid, status, block_index, free_blocks, last, input ready);
    modport sink (input valid, status, block_index, free_blocks, last, output ready);
endinterface

FILE: src/iba_ctrl.sv
// controller state machine of the allocator
module iba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  iba_pkg::stat_t st,
    output iba_pkg::ctrl_t ctl
);
    import iba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_ALLOC, S_FREE_RD, S_FREE_WR,
        S_LIST_RD, S_LIST_EMIT, S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] status_reg, status_next;
    logic [1:0] kind_reg, kind_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        kind_next   = kind_reg;
        ctl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    ctl.load = 1'b1;
                    if (st.in_cmd == CMD_INSERT || st.in_cmd == CMD_DELETE
                        || st.in_cmd == CMD_LIST)
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (st.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                kind_next  = IDX_ZERO;
                state_next = S_EMIT;
                if (st.cmd_q == CMD_INSERT)
                begin
                    if (st.count_bad)
                        status_next = ST_BAD_COUNT;
                    else if (st.no_space)
                        status_next = ST_NO_SPACE;
                    else if (st.match)
                        status_next = ST_EXISTS;
                    else if (!st.vacant)
                        status_next = ST_FULL;
                    else
                        state_next = S_ALLOC;
                end
                else if (!st.match)
                    status_next = ST_NOT_FOUND;
                else if (st.cmd_q == CMD_DELETE)
                    state_next = S_FREE_RD;
                else
                    state_next = S_LIST_RD;
            end
            S_ALLOC:
            begin
                ctl.alloc_step = 1'b1;
                if (st.alloc_last)
                begin
                    status_next = ST_OK;
                    kind_next   = IDX_START;
                    state_next  = S_EMIT;
                end
            end
            S_FREE_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                ctl.free_wr = 1'b1;
                if (st.blk_last)
                begin
                    status_next = ST_OK;
                    kind_next   = IDX_ZERO;
                    state_next  = S_EMIT;
                end
                else
                    state_next = S_FREE_RD;
            end
            S_LIST_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_LIST_EMIT;
            end
            S_LIST_EMIT:
            begin
                ctl.emit_status = ST_OK;
                ctl.emit_kind   = IDX_LIST;
                ctl.emit_last   = st.blk_last;
                if (st.out_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.list_step = 1'b1;
                    state_next    = st.blk_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_EMIT:
            begin
                ctl.emit_status = status_reg;
                ctl.emit_kind   = kind_reg;
                ctl.emit_last   = 1'b1;
                if (st.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and held result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            kind_reg   <= IDX_ZERO;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            kind_reg   <= kind_next;
        end
    end

endmodule

FILE: src/iba_datapath.sv
// bitmap, file table, block lists and result register
module iba_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [1:0]                in_cmd,
    input  logic [iba_pkg::KEY_W-1:0] in_key,
    input  logic [iba_pkg::CNT_W-1:0] in_count,
    input  iba_pkg::ctrl_t            ctl,
    output iba_pkg::stat_t            st,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [2:0]                out_status,
    output logic [iba_pkg::BLK_W-1:0] out_index,
    output logic [iba_pkg::FREE_W-1:0] out_free_blocks,
    output logic                      out_last
);
    import iba_pkg::*;

    localparam int ADDR_W = SLOT_W + LIST_W;

    logic [1:0]             cmd_q;
    logic [KEY_W-1:0]       key_q;
    logic [CNT_W-1:0]       cnt_q;
    logic [DISK_BLOCKS-1:0] used_reg;
    logic [FREE_W-1:0]      free_reg;
    logic [FILE_SLOTS-1:0]  valid_reg;
    logic [KEY_W-1:0]       key_mem [FILE_SLOTS];
    logic [CNT_W-1:0]       len_mem [FILE_SLOTS];
    logic [BLK_W-1:0]       list_mem [1 << ADDR_W];
    logic [BLK_W-1:0]       rd_reg;
    logic [SLOT_W-1:0]      scan_reg, match_slot_reg, vac_slot_reg;
    logic                   match_reg, vac_reg;
    logic [BLK_W-1:0]       blk_reg, start_reg;
    logic [CNT_W-1:0]       got_reg;
    logic [LIST_W-1:0]      idx_reg;
    logic                   blk_free, alloc_last, blk_last, hit;
    logic [ADDR_W-1:0]      rd_addr;

    assign blk_free   = !used_reg[blk_reg];
    assign alloc_last = blk_free && (got_reg == cnt_q - CNT_W'(1));
    assign blk_last   = ({1'b0, idx_reg} == len_mem[match_slot_reg] - CNT_W'(1));
    assign hit        = valid_reg[scan_reg] && (key_mem[scan_reg] == key_q);
    assign rd_addr    = {match_slot_reg, idx_reg};

    // status towards the controller
    always_comb
    begin
        st.in_valid   = in_valid;
        st.in_cmd     = in_cmd;
        st.cmd_q      = cmd_q;
        st.count_bad  = (cnt_q == '0) || (cnt_q > CNT_W'(MAX_FILE_BLOCKS));
        st.no_space   = {1'b0, cnt_q} > free_reg;
        st.match      = match_reg;
        st.vacant     = vac_reg;
        st.scan_last  = scan_reg == SLOT_W'(FILE_SLOTS - 1);
        st.alloc_last = alloc_last;
        st.blk_last   = blk_last;
        st.out_free   = !out_valid || out_ready;
    end

    // control state, bitmap and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            free_reg  <= FREE_W'(DISK_BLOCKS);
            valid_reg <= '0;
            out_valid <= 1'b0;
            scan_reg  <= '0;
            match_reg <= 1'b0;
            vac_reg   <= 1'b0;
            blk_reg   <= '0;
            got_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                scan_reg  <= '0;
                match_reg <= 1'b0;
                vac_reg   <= 1'b0;
                blk_reg   <= '0;
                got_reg   <= '0;
                idx_reg   <= '0;
            end
            // slot scan: first matching key and first vacant slot
            if (ctl.scan_step)
            begin
                scan_reg <= scan_reg + SLOT_W'(1);
                if (hit && !match_reg)
                    match_reg <= 1'b1;
                if (!valid_reg[scan_reg] && !vac_reg)
                    vac_reg <= 1'b1;
            end
            // first-fit claim, one block a cycle
            if (ctl.alloc_step)
            begin
                blk_reg <= blk_reg + BLK_W'(1);
                if (blk_free)
                begin
                    used_reg[blk_reg] <= 1'b1;
                    got_reg           <= got_reg + CNT_W'(1);
                end
                if (alloc_last)
                begin
                    valid_reg[vac_slot_reg] <= 1'b1;
                    free_reg                <= free_reg - FREE_W'(cnt_q);
                end
            end
            // release one listed block
            if (ctl.free_wr)
            begin
                idx_reg <= idx_reg + LIST_W'(1);
                if (used_reg[rd_reg])
                begin
                    used_reg[rd_reg] <= 1'b0;
                    free_reg         <= free_reg + FREE_W'(1);
                end
                if (blk_last)
                    valid_reg[match_slot_reg] <= 1'b0;
            end
            if (ctl.list_step)
                idx_reg <= idx_reg + LIST_W'(1);
            // result register
            if (ctl.emit)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // payload registers and file table
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_q <= in_cmd;
            key_q <= in_key;
            cnt_q <= in_count;
        end
        if (ctl.scan_step)
        begin
            if (hit && !match_reg)
                match_slot_reg <= scan_reg;
            if (!valid_reg[scan_reg] && !vac_reg)
                vac_slot_reg <= scan_reg;
        end
        if (ctl.alloc_step && blk_free && got_reg == '0)
            start_reg <= blk_reg;
        if (ctl.alloc_step && alloc_last)
        begin
            key_mem[vac_slot_reg] <= key_q;
            len_mem[vac_slot_reg] <= cnt_q;
        end
        if (ctl.emit)
        begin
            out_status      <= ctl.emit_status;
            out_free_blocks <= free_reg;
            out_last        <= ctl.emit_last;
            case (ctl.emit_kind)
                IDX_START: out_index <= start_reg;
                IDX_LIST:  out_index <= rd_reg;
                default:   out_index <= '0;
            endcase
        end
    end

    // block list memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.alloc_step && blk_free)
            list_mem[{vac_slot_reg, got_reg[LIST_W-1:0]}] <= blk_reg;
        if (ctl.mem_rd)
            rd_reg <= list_mem[rd_addr];
    end

endmodule

FILE: src/indexed_block_allocator.sv
// Indexed block allocator: one request at a time. Every insert, delete or list first scans
// the 32-slot file table, one slot a cycle. An insert then walks the free-block bitmap
// one block a cycle until its blocks are claimed. Delete and list read each listed block
// through the registered read of the block list memory before freeing or emitting it;
// list also waits whenever the response is not taken. Errors give one response after
// the scan. The bitmap and table valid bits clear at reset, so the block takes requests
// straight away. A response waiting in the output register does not keep the next
// request from being accepted.
module indexed_block_allocator (
    input  logic       clk,
    input  logic       rst_n,
    alloc_req_if.sink  req,
    alloc_rsp_if.source rsp
);
    import iba_pkg::*;

    ctrl_t ctl;
    stat_t st;

    assign req.ready = ctl.in_ready;

    // sequencing
    iba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    // storage and result register
    iba_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (req.valid),
        .in_cmd          (req.cmd),
        .in_key          (req.file_key),
        .in_count        (req.block_count),
        .ctl             (ctl),
        .st              (st),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_status      (rsp.status),
        .out_index       (rsp.block_index),
        .out_free_blocks (rsp.free_blocks),
        .out_last        (rsp.last)
    );

endmodule

FILE: src/iba_checker.sv
// port-level checks of the allocator and their binding
`include "assert_macros.svh"

module iba_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       last
);
    import iba_pkg::*;

    // a stalled response stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // a real command keeps the block busy in the next cycle
    `ASSERT_NEXT(a_busy_after_cmd, clk, rst_n,
        in_valid && in_ready && (in_cmd == CMD_INSERT || in_cmd == CMD_DELETE
        || in_cmd == CMD_LIST), !in_ready)
    // status codes stay in range
    `ASSERT_SAME(a_status_range, clk, rst_n, out_valid, status <= ST_BAD_COUNT)
    // a failure is always a single, final response
    `ASSERT_SAME(a_error_last, clk, rst_n, out_valid && status != ST_OK, last)

endmodule

bind indexed_block_allocator iba_checker u_iba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.cmd),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .last      (rsp.last)
);

FILE: tb/tb_indexed_block_allocator.sv
// testbench for the indexed block allocator: directed table then random traffic
module tb_indexed_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import iba_pkg::*;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] block_index;
        logic [7:0] free_blocks;
        logic       last;
    } rsp_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] file_key;
        logic [6:0]  block_count;
        bit          typed;
        logic [2:0]  want_status;
        logic [6:0]  want_index;
        logic [7:0]  want_free;
    } step_t;

    logic clk;
    logic rst_n;

    alloc_req_if req ();
    alloc_rsp_if rsp ();

    indexed_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // shadow allocator state
    bit          blk_taken [DISK_BLOCKS];
    int          blocks_free;
    bit          entry_live [FILE_SLOTS];
    logic [15:0] entry_key [FILE_SLOTS];
    int          entry_len [FILE_SLOTS];
    logic [6:0]  entry_blocks [FILE_SLOTS][MAX_FILE_BLOCKS];

    rsp_t        pending_rsp [$];
    logic [15:0] live_keys [$];
    int          mismatches;
    int          items_sent;
    int          rsp_seen;
    int          lists_done;
    bit          quiet_req;
    bit          quiet_rsp;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("indexed_block_allocator regression: fail");
        $finish;
    end

    function automatic int lookup_entry(logic [15:0] key);
        for (int s = 0; s < FILE_SLOTS; s++)
            if (entry_live[s] && entry_key[s] == key)
                return s;
        return -1;
    endfunction

    function automatic void push_rsp(logic [2:0] st, logic [6:0] idx, bit lst);
        rsp_t r;
        r.status      = st;
        r.block_index = idx;
        r.free_blocks = blocks_free[7:0];
        r.last        = lst;
        pending_rsp.push_back(r);
    endfunction

    // work out the responses of one request and update the shadow state
    function automatic void allocate_predict(logic [1:0] cmd, logic [15:0] key,
                                             logic [6:0] cnt);
        int s;
        int got;
        s = lookup_entry(key);
        if (cmd == CMD_INSERT)
        begin
            if (cnt == 0 || cnt > MAX_FILE_BLOCKS)
                push_rsp(ST_BAD_COUNT, '0, 1'b1);
            else if (cnt > blocks_free)
                push_rsp(ST_NO_SPACE, '0, 1'b1);
            else if (s >= 0)
                push_rsp(ST_EXISTS, '0, 1'b1);
            else
            begin
                s = -1;
                for (int f = FILE_SLOTS - 1; f >= 0; f--)
                    if (!entry_live[f])
                        s = f;
                if (s < 0)
                    push_rsp(ST_FULL, '0, 1'b1);
                else
                begin
                    got = 0;
                    for (int b = 0; b < DISK_BLOCKS && got < cnt; b++)
                        if (!blk_taken[b])
                        begin
                            blk_taken[b] = 1'b1;
                            entry_blocks[s][got] = b[6:0];
                            got++;
                        end
                    entry_live[s] = 1'b1;
                    entry_key[s]  = key;
                    entry_len[s]  = got;
                    blocks_free  -= got;
                    live_keys.push_back(key);
                    push_rsp(ST_OK, entry_blocks[s][0], 1'b1);
                end
            end
        end
        else if (cmd == CMD_DELETE || cmd == CMD_LIST)
        begin
            if (s < 0)
                push_rsp(ST_NOT_FOUND, '0, 1'b1);
            else if (cmd == CMD_DELETE)
            begin
                for (int i = 0; i < entry_len[s]; i++)
                    if (blk_taken[entry_blocks[s][i]])
                    begin
                        blk_taken[entry_blocks[s][i]] = 1'b0;
                        blocks_free++;
                    end
                entry_live[s] = 1'b0;
                foreach (live_keys[k])
                    if (live_keys[k] == key)
                    begin
                        live_keys.delete(k);
                        break;
                    end
                push_rsp(ST_OK, '0, 1'b1);
            end
            else
            begin
                for (int i = 0; i < entry_len[s]; i++)
                    push_rsp(ST_OK, entry_blocks[s][i], i == entry_len[s] - 1);
                lists_done++;
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // send one request, holding it until the transfer; valid stays up for a following one
    task automatic send_req(logic [1:0] cmd, logic [15:0] key, logic [6:0] cnt);
        while (!quiet_req && $urandom_range(99) < 14)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= cmd;
        req.file_key    <= key;
        req.block_count <= cnt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        allocate_predict(cmd, key, cnt);
        items_sent++;
        @(negedge clk);
    endtask

    // response side: random stall and compare at each transfer
    always @(negedge clk)
        if (rst_n)
            rsp.ready <= quiet_rsp || ($urandom_range(99) >= 14);

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response, status", rsp.status, -1);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.block_index !== want.block_index)
                    report_mismatch("block_index", rsp.block_index, want.block_index);
                if (rsp.free_blocks !== want.free_blocks)
                    report_mismatch("free_blocks", rsp.free_blocks, want.free_blocks);
                if (rsp.last !== want.last)
                    report_mismatch("last", rsp.last, want.last);
            end
        end
    end

    function automatic step_t row(logic [1:0] c, logic [15:0] k, logic [6:0] n, bit t = 0,
                                  logic [2:0] st = ST_OK, logic [6:0] ix = '0,
                                  logic [7:0] fr = '0);
        step_t r;
        r.cmd = c; r.file_key = k; r.block_count = n; r.typed = t;
        r.want_status = st; r.want_index = ix; r.want_free = fr;
        return r;
    endfunction

    initial
    begin
        step_t    plan [$];
        rsp_t     head;
        int       waited;
        int       pick;
        logic [15:0] key;
        logic [1:0]  cmd;
        logic [6:0]  cnt;

        mismatches  = 0; items_sent = 0; rsp_seen = 0; lists_done = 0;
        quiet_req   = 1'b0;
        quiet_rsp   = 1'b0;
        blocks_free = DISK_BLOCKS;
        foreach (blk_taken[b]) blk_taken[b] = 1'b0;
        foreach (entry_live[s]) entry_live[s] = 1'b0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.cmd         = CMD_INSERT;
        req.file_key    = '0;
        req.block_count = '0;
        rsp.ready       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed table: extremes, every command, every error code
        plan.push_back(row(CMD_LIST,   16'h0000, 7'd0,   1, ST_NOT_FOUND, 0, 128));
        plan.push_back(row(CMD_DELETE, 16'hffff, 7'd0,   1, ST_NOT_FOUND, 0, 128));
        plan.push_back(row(CMD_INSERT, 16'h0001, 7'd0,   1, ST_BAD_COUNT, 0, 128));
        plan.push_back(row(CMD_INSERT, 16'h0001, 7'd65,  1, ST_BAD_COUNT, 0, 128));
        plan.push_back(row(CMD_INSERT, 16'h0001, 7'd127, 1, ST_BAD_COUNT, 0, 128));
        plan.push_back(row(CMD_INSERT, 16'hffff, 7'd64,  1, ST_OK, 0, 64));
        plan.push_back(row(CMD_INSERT, 16'hffff, 7'd1,   1, ST_EXISTS, 0, 64));
        plan.push_back(row(CMD_INSERT, 16'h0000, 7'd1,   1, ST_OK, 64, 63));
        plan.push_back(row(CMD_INSERT, 16'h5555, 7'd64,  1, ST_NO_SPACE, 0, 63));
        plan.push_back(row(CMD_INSERT, 16'haaaa, 7'd63,  1, ST_OK, 65, 0));
        plan.push_back(row(CMD_LIST,   16'h0000, 7'd127));
        plan.push_back(row(CMD_LIST,   16'hffff, 7'd0));
        plan.push_back(row(2'd3,       16'hffff, 7'd127));
        plan.push_back(row(CMD_DELETE, 16'h0000, 7'd0,   1, ST_OK, 0, 1));
        plan.push_back(row(CMD_INSERT, 16'h1234, 7'd2,   1, ST_NO_SPACE, 0, 1));
        plan.push_back(row(CMD_DELETE, 16'hffff, 7'd0,   1, ST_OK, 0, 65));
        plan.push_back(row(CMD_INSERT, 16'h1234, 7'd3));
        plan.push_back(row(CMD_LIST,   16'h1234, 7'd0));
        plan.push_back(row(CMD_DELETE, 16'haaaa, 7'd0));
        plan.push_back(row(CMD_DELETE, 16'h1234, 7'd0,   1, ST_OK, 0, 128));
        // fill the table with single blocks, then one more is refused
        for (int s = 0; s < FILE_SLOTS; s++)
            plan.push_back(row(CMD_INSERT, 16'(16'h0100 + s), 7'd1));
        plan.push_back(row(CMD_INSERT, 16'h0200, 7'd1, 1, ST_FULL, 0, 96));
        for (int s = 0; s < FILE_SLOTS; s++)
            plan.push_back(row(CMD_DELETE, 16'(16'h0100 + s), 7'd0));

        foreach (plan[i])
        begin
            send_req(plan[i].cmd, plan[i].file_key, plan[i].block_count);
            if (plan[i].typed)
            begin
                head = pending_rsp[pending_rsp.size() - 1];
                if (head.status !== plan[i].want_status)
                    report_mismatch("table status", head.status, plan[i].want_status);
                if (head.block_index !== plan[i].want_index)
                    report_mismatch("table index", head.block_index, plan[i].want_index);
                if (head.free_blocks !== plan[i].want_free)
                    report_mismatch("table free", head.free_blocks, plan[i].want_free);
            end
        end

        // random traffic: mostly live keys, small counts, some noise
        for (int n = 0; n < 365; n++)
        begin
            quiet_req = (n >= 200 && n < 260);
            quiet_rsp = quiet_req;
            pick = $urandom_range(99);
            if (live_keys.size() != 0 && $urandom_range(99) < 60)
                key = live_keys[$urandom_range(live_keys.size() - 1)];
            else if ($urandom_range(3) == 0)
                key = 16'($urandom);
            else
                key = 16'($urandom_range(15));
            if (pick < 45)
            begin
                cmd = CMD_INSERT;
                if ($urandom_range(19) == 0)
                    cnt = 7'($urandom);
                else if ($urandom_range(9) == 0)
                    cnt = 7'($urandom_range(64, 33));
                else
                    cnt = 7'($urandom_range(12, 1));
            end
            else if (pick < 70)
            begin
                cmd = CMD_DELETE;
                cnt = 7'($urandom);
            end
            else if (pick < 96)
            begin
                cmd = CMD_LIST;
                cnt = 7'($urandom);
            end
            else
            begin
                cmd = 2'd3;
                cnt = 7'($urandom);
            end
            send_req(cmd, key, cnt);
        end
        req.valid <= 1'b0;
        quiet_req = 1'b0;
        quiet_rsp = 1'b0;

        // drain, then a quiet tail
        waited = 0;
        while (pending_rsp.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);

        $display("sent %0d requests, %0d lists, checked %0d responses, %0d mismatches",
                 items_sent, lists_done, rsp_seen, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("indexed_block_allocator regression: pass");
        else
            $display("indexed_block_allocator regression: fail");
        $finish;
    end
endmodule
